/* src/ittl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittl_pkg
// Shared types, codes and ones' complement helper for the IPv4 TTL
// decrement / checksum update core.
// ----------------------------------------------------------------------------
package ittl_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_FORWARD = 2'd0;
  localparam logic [1:0] STATUS_BADSUM  = 2'd1;
  localparam logic [1:0] STATUS_EXPIRED = 2'd2;

  // Header offsets of interest
  localparam logic [5:0] POS_TTL     = 6'd8;
  localparam logic [5:0] POS_CSUM_HI = 6'd10;
  localparam logic [5:0] POS_CSUM_LO = 6'd11;

  localparam logic [15:0] SUM_GOOD = 16'hffff;

  // Header state captured when the last byte transfers
  typedef struct packed {
    logic [15:0] sum;       // folded sum of completed words
    logic [7:0]  pend;      // trailing high byte, low half missing
    logic        add_pend;  // odd byte count: pend still to be added
    logic [7:0]  ttl;
    logic [15:0] csum;
  } hdr_snap_t;

  // Ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

/* src/ittl_hdr_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittl_hdr_accum
// Per-byte header walk: word pairing, running ones' complement sum and
// capture of the TTL and stored checksum. Clears after the last byte.
// ----------------------------------------------------------------------------
module ittl_hdr_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          header_byte_i,
  input  logic                last_byte_i,
  output ittl_pkg::hdr_snap_t snap_o
);

  logic [15:0] sum_q, sum_d;
  logic [5:0]  pos_q;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [15:0] csum_q, csum_d;

  always_comb begin
    ttl_d  = ttl_q;
    csum_d = csum_q;
    if (pos_q == ittl_pkg::POS_TTL) begin
      ttl_d = header_byte_i;
    end else if (pos_q == ittl_pkg::POS_CSUM_HI) begin
      csum_d = {header_byte_i, csum_q[7:0]};
    end else if (pos_q == ittl_pkg::POS_CSUM_LO) begin
      csum_d = {csum_q[15:8], header_byte_i};
    end

    // even offset: high half of a word; odd offset closes the word
    if (!pos_q[0]) begin
      pend_d = header_byte_i;
      sum_d  = sum_q;
    end else begin
      pend_d = 8'd0;
      sum_d  = ittl_pkg::oc_add(sum_q, {pend_q, header_byte_i});
    end
  end

  always_comb begin
    snap_o.sum      = sum_d;
    snap_o.pend     = pend_d;
    snap_o.add_pend = ~pos_q[0];
    snap_o.ttl      = ttl_d;
    snap_o.csum     = csum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pos_q  <= '0;
      pend_q <= '0;
      ttl_q  <= '0;
      csum_q <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        sum_q  <= '0;
        pos_q  <= '0;
        pend_q <= '0;
        ttl_q  <= '0;
        csum_q <= '0;
      end else begin
        sum_q  <= sum_d;
        pos_q  <= pos_q + 6'd1;  // wraps modulo 64
        pend_q <= pend_d;
        ttl_q  <= ttl_d;
        csum_q <= csum_d;
      end
    end
  end

endmodule

/* src/ittl_result.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittl_result
// Final checksum verdict, TTL decrement and RFC 1624 style incremental
// checksum update from a captured header snapshot.
// ----------------------------------------------------------------------------
module ittl_result (
  input  ittl_pkg::hdr_snap_t snap_i,
  input  logic                skip_mode_i,
  output logic [1:0]          status_o,
  output logic [7:0]          ttl_o,
  output logic [15:0]         csum_o
);

  logic [15:0] sum_fin;
  logic [7:0]  ttl_dec;
  logic [15:0] upd_acc;
  logic [15:0] upd_csum;

  always_comb begin
    sum_fin = snap_i.add_pend ? ittl_pkg::oc_add(snap_i.sum, {snap_i.pend, 8'd0})
                              : snap_i.sum;
    ttl_dec = snap_i.ttl - 8'd1;

    // HC' = ~(~HC + ~(ttl << 8) + (ttl' << 8))
    upd_acc  = ittl_pkg::oc_add(~snap_i.csum, ~{snap_i.ttl, 8'd0});
    upd_acc  = ittl_pkg::oc_add(upd_acc, {ttl_dec, 8'd0});
    upd_csum = ~upd_acc;

    if (!skip_mode_i && (sum_fin != ittl_pkg::SUM_GOOD)) begin
      status_o = ittl_pkg::STATUS_BADSUM;
      ttl_o    = snap_i.ttl;
      csum_o   = snap_i.csum;
    end else if (skip_mode_i && (ttl_dec == 8'd0)) begin
      status_o = ittl_pkg::STATUS_EXPIRED;
      ttl_o    = ttl_dec;
      csum_o   = snap_i.csum;
    end else begin
      status_o = ittl_pkg::STATUS_FORWARD;
      ttl_o    = ttl_dec;
      csum_o   = upd_csum;
    end
  end

endmodule

/* src/ipv4_ttl_decrement_checksum_update_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_ttl_decrement_checksum_update_core
// IPv4 header walker: checksum check, TTL decrement, incremental checksum.
// ----------------------------------------------------------------------------
// Throughput: one header byte per cycle, across headers, unless the output stalls.
// Result path: after the last byte transfers, the header goes to the snapshot
//   register, then to the result register; an output stall holds it back.
// Reset: async active low; clears header state, pipeline valids and mode.
// ----------------------------------------------------------------------------
module ipv4_ttl_decrement_checksum_update_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        skip_check_mode_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  header_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  ttl_out_o,
  output logic [15:0] checksum_out_o
);

  logic                mode_q;
  logic                in_fire;
  logic                out_load;
  logic                fin_vld_q;
  ittl_pkg::hdr_snap_t snap_d, snap_q;
  logic [1:0]          status_d;
  logic [7:0]          ttl_d;
  logic [15:0]         csum_d;

  assign cfg_ready_o = 1'b1;

  assign out_load   = fin_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !fin_vld_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= skip_check_mode_i;
    end
  end

  ittl_hdr_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_fire),
    .header_byte_i (header_byte_i),
    .last_byte_i   (last_byte_i),
    .snap_o        (snap_d)
  );

  // Snapshot stage: holds a finished header until the result register frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (in_fire && last_byte_i) begin
      fin_vld_q <= 1'b1;
    end else if (out_load) begin
      fin_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) begin
      snap_q <= snap_d;
    end
  end

  ittl_result u_result (
    .snap_i      (snap_q),
    .skip_mode_i (mode_q),
    .status_o    (status_d),
    .ttl_o       (ttl_d),
    .csum_o      (csum_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o       <= status_d;
      ttl_out_o      <= ttl_d;
      checksum_out_o <= csum_d;
    end
  end

endmodule

/* src/ittl_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittl_chk
// Port-level checker for the IPv4 TTL / checksum core, bound to the top.
// ----------------------------------------------------------------------------
module ittl_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [7:0]  ttl_out_o,
  input logic [15:0] checksum_out_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(ttl_out_o) && $stable(checksum_out_o))
    else $error("result changed while stalled");

  // a new result follows a last byte transfer, via the snapshot and result registers
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_byte_i, 2))
    else $error("result without a finished header");

  // input backpressure only comes from a stalled output
  a_bp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output free");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ittl_pkg::STATUS_FORWARD)
      || (status_o == ittl_pkg::STATUS_BADSUM)
      || (status_o == ittl_pkg::STATUS_EXPIRED))
    else $error("undefined status code");

  // expired always means the decremented TTL reached zero
  a_expired_ttl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ittl_pkg::STATUS_EXPIRED) |-> ttl_out_o == 8'd0)
    else $error("expired with nonzero TTL");

endmodule

bind ipv4_ttl_decrement_checksum_update_core ittl_chk u_ittl_chk (.*);

/* tb/tb_ipv4_ttl_decrement_checksum_update_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_ttl_decrement_checksum_update_core
// Self-checking bench for the IPv4 TTL decrement / checksum update core.
// A short directed table covers extreme bytes, short and odd-length headers,
// TTL wrap and expiry. Random headers follow, mostly with a correct checksum.
// Some are corrupted, and lengths run from a single byte up past the 64-byte
// offset wrap. Each accepted byte goes through a local header model. Results
// are checked in order against the model or, for fixed rows, the table. Both
// modes are exercised, and the sender and receiver stall at random.
// ----------------------------------------------------------------------------
module tb_ipv4_ttl_decrement_checksum_update_core;

  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_SKIP  = 1'b1;
  localparam int   LATENCY    = 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  ttl;
    logic [15:0] csum;
  } hdr_result_t;

  typedef struct {
    logic        mode;
    logic [7:0]  data;
    logic        last;
    bit          fixed;
    hdr_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        skip_check_mode_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  header_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [7:0]  ttl_out_o;
  logic [15:0] checksum_out_o;

  ipv4_ttl_decrement_checksum_update_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .skip_check_mode_i (skip_check_mode_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .header_byte_i     (header_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .ttl_out_o         (ttl_out_o),
    .checksum_out_o    (checksum_out_o)
  );

  always #10 clk_i = ~clk_i;

  // Header model state
  logic        mode_q = MODE_CHECK;
  logic [15:0] hdr_sum_q = '0;
  logic [5:0]  hdr_pos_q = '0;
  logic [7:0]  hdr_pend_q = '0;
  logic [7:0]  hdr_ttl_q = '0;
  logic [15:0] hdr_csum_q = '0;

  hdr_result_t pending_results[$];
  hdr_result_t head_result;
  int          mismatch_count = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  stim_row_t   dir_tab[$];

  function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic stim_row_t row(input logic mode, input logic [7:0] data,
                                    input logic last, input bit fixed,
                                    input logic [1:0] status, input logic [7:0] ttl,
                                    input logic [15:0] csum);
    stim_row_t r;
    r.mode  = mode;
    r.data  = data;
    r.last  = last;
    r.fixed = fixed;
    r.want  = '{status, ttl, csum};
    return r;
  endfunction

  // Advance the header model by one accepted byte; on the last byte give
  // the status, TTL and checksum to write back.
  task automatic update_header_model(input logic [7:0] data, input logic last,
                                     output hdr_result_t res, output bit done);
    logic [15:0] total;
    logic [15:0] acc;
    logic [7:0]  ttl_dec;
    done = 1'b0;
    res  = '0;
    if (hdr_pos_q == ittl_pkg::POS_TTL) hdr_ttl_q = data;
    else if (hdr_pos_q == ittl_pkg::POS_CSUM_HI) hdr_csum_q[15:8] = data;
    else if (hdr_pos_q == ittl_pkg::POS_CSUM_LO) hdr_csum_q[7:0] = data;
    if (!hdr_pos_q[0]) begin
      hdr_pend_q = data;
    end else begin
      hdr_sum_q  = csum_add(hdr_sum_q, {hdr_pend_q, data});
      hdr_pend_q = '0;
    end
    total = hdr_sum_q;
    // odd byte count: trailing high byte with a zero low half
    if (!hdr_pos_q[0]) total = csum_add(total, {hdr_pend_q, 8'h00});
    hdr_pos_q = hdr_pos_q + 6'd1;
    if (last) begin
      ttl_dec = hdr_ttl_q - 8'd1;
      if (mode_q == MODE_CHECK && total != ittl_pkg::SUM_GOOD) begin
        res = '{ittl_pkg::STATUS_BADSUM, hdr_ttl_q, hdr_csum_q};
      end else if (mode_q == MODE_SKIP && ttl_dec == 8'd0) begin
        res = '{ittl_pkg::STATUS_EXPIRED, ttl_dec, hdr_csum_q};
      end else begin
        acc = csum_add(~hdr_csum_q, ~{hdr_ttl_q, 8'h00});
        acc = csum_add(acc, {ttl_dec, 8'h00});
        res = '{ittl_pkg::STATUS_FORWARD, ttl_dec, ~acc};
      end
      done       = 1'b1;
      hdr_sum_q  = '0;
      hdr_pos_q  = '0;
      hdr_pend_q = '0;
      hdr_ttl_q  = '0;
      hdr_csum_q = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last, input bit fixed,
                           input hdr_result_t want);
    hdr_result_t got;
    bit          done;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    header_byte_i <= data;
    last_byte_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    update_header_model(data, last, got, done);
    if (done) pending_results.push_back(fixed ? want : got);
  endtask

  // Mode changes only with the core idle: all results out, pipeline flushed.
  task automatic set_mode(input logic mode);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    skip_check_mode_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    mode_q = mode;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_header(output int len);
    logic [7:0]  hdr [80];
    logic [15:0] s;
    int          r;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(24, 12);
    else if (r < 85) len = $urandom_range(11, 1);
    else if (r < 95) len = $urandom_range(60, 25);
    else len = $urandom_range(80, 61);
    for (int i = 0; i < len; i++) hdr[i] = 8'($urandom_range(255));
    if ($urandom_range(1) == 0) hdr[0] = 8'h45;
    if (len > ittl_pkg::POS_TTL) begin
      case ($urandom_range(7))
        0: hdr[ittl_pkg::POS_TTL] = 8'h00;
        1: hdr[ittl_pkg::POS_TTL] = 8'h01;
        2: hdr[ittl_pkg::POS_TTL] = 8'h02;
        3: hdr[ittl_pkg::POS_TTL] = 8'hff;
        default: ;
      endcase
    end
    if (len > ittl_pkg::POS_CSUM_LO && $urandom_range(99) < 85) begin
      hdr[ittl_pkg::POS_CSUM_HI] = 8'h00;
      hdr[ittl_pkg::POS_CSUM_LO] = 8'h00;
      s = '0;
      for (int i = 0; i < len; i += 2)
        s = csum_add(s, {hdr[i], (i + 1 < len) ? hdr[i + 1] : 8'h00});
      {hdr[ittl_pkg::POS_CSUM_HI], hdr[ittl_pkg::POS_CSUM_LO]} = ~s;
      // occasional single bit error on a good header
      if ($urandom_range(99) < 8) begin
        r = $urandom_range(len - 1);
        hdr[r] = hdr[r] ^ (8'h01 << $urandom_range(7));
      end
    end
    for (int i = 0; i < len; i++) send_byte(hdr[i], i == len - 1, 1'b0, '0);
  endtask

  // Receiver: check each result transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual status %0d ttl %02h csum %04h",
                 $time, status_o, ttl_out_o, checksum_out_o);
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status) begin
          mismatch_count++;
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, head_result.status, status_o);
        end
        if (ttl_out_o !== head_result.ttl) begin
          mismatch_count++;
          $display("%0t: ttl mismatch: expected %02h actual %02h",
                   $time, head_result.ttl, ttl_out_o);
        end
        if (checksum_out_o !== head_result.csum) begin
          mismatch_count++;
          $display("%0t: checksum mismatch: expected %04h actual %04h",
                   $time, head_result.csum, checksum_out_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    int n_bytes;
    int n_hdrs;
    int len;
    rst_ni            <= 1'b0;
    cfg_valid_i       <= 1'b0;
    skip_check_mode_i <= 1'b0;
    in_valid_i        <= 1'b0;
    header_byte_i     <= 8'h00;
    last_byte_i       <= 1'b0;
    out_ready_i       <= 1'b0;

    // single-byte headers: odd count, bad sum, nothing captured
    dir_tab.push_back(row(MODE_CHECK, 8'h00, 1'b1, 1'b1,
                          ittl_pkg::STATUS_BADSUM, 8'h00, 16'h0000));
    dir_tab.push_back(row(MODE_CHECK, 8'hff, 1'b1, 1'b1,
                          ittl_pkg::STATUS_BADSUM, 8'h00, 16'h0000));
    // two bytes summing to all ones, TTL zero wraps in check mode
    dir_tab.push_back(row(MODE_CHECK, 8'hff, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'hff, 1'b1, 1'b0, '0, '0, '0));
    // 12-byte header with a good checksum, TTL 1 forwarded in check mode
    dir_tab.push_back(row(MODE_CHECK, 8'h45, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'h00, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'h00, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'h1c, 1'b0, 1'b0, '0, '0, '0));
    for (int i = 0; i < 4; i++)
      dir_tab.push_back(row(MODE_CHECK, 8'h00, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'h01, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'h11, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'hb9, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_CHECK, 8'hd2, 1'b1, 1'b0, '0, '0, '0));
    // skip mode, 9-byte header ending on TTL 1: expires, checksum never seen
    for (int i = 0; i < 8; i++)
      dir_tab.push_back(row(MODE_SKIP, 8'h00, 1'b0, 1'b0, '0, '0, '0));
    dir_tab.push_back(row(MODE_SKIP, 8'h01, 1'b1, 1'b1,
                          ittl_pkg::STATUS_EXPIRED, 8'h00, 16'h0000));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_idle_pct  = 17;
    out_idle_pct = 75;
    set_mode(MODE_CHECK);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != mode_q) set_mode(dir_tab[i].mode);
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].fixed, dir_tab[i].want);
    end

    for (int chunk = 0; chunk < 6; chunk++) begin
      in_idle_pct  = (chunk < 2) ? 17 : (chunk < 4) ? 75 : 0;
      out_idle_pct = (chunk < 2) ? 75 : (chunk < 4) ? 17 : 0;
      set_mode(chunk[0] ? MODE_SKIP : MODE_CHECK);
      n_bytes = 0;
      n_hdrs  = 0;
      while (n_bytes < 50 || n_hdrs < 2) begin
        send_random_header(len);
        n_bytes += len;
        n_hdrs++;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("ipv4_ttl_decrement_checksum_update_core regression: pass");
    else
      $display("ipv4_ttl_decrement_checksum_update_core regression: fail");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("ipv4_ttl_decrement_checksum_update_core regression: fail");
    $finish;
  end

endmodule
